@@ hdl/fat12_file_sector_sequencer_core_assert.svh @@
// ----------------------------------------------------------------------------
// FAT12 sector sequencer assertion macros
// Concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FAT12_FILE_SECTOR_SEQUENCER_CORE_ASSERT_SVH
`define FAT12_FILE_SECTOR_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FSS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define FSS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define FSS_ASSERT(lbl, clk, rstn, prop)
`define FSS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ hdl/fat12fss_pkg.sv @@
// ----------------------------------------------------------------------------
// FAT12 sector sequencer package
// Item codes, queue entry type and fixed constants.
// ----------------------------------------------------------------------------
package fat12fss_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_OPEN = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] CFG_SPC       = 2'd0;
  localparam logic [1:0] CFG_DATA_LBA  = 2'd1;
  localparam logic [1:0] CFG_ROOT_LBA  = 2'd2;
  localparam logic [1:0] CFG_ROOT_SIZE = 2'd3;

  localparam int unsigned SectorBytes  = 512;
  localparam int unsigned MaxReadBytes = 8192;
  localparam logic [11:0] CHAIN_END    = 12'hFF8;
  localparam logic [11:0] CLUSTER_MASK = 12'hFFF;
  localparam logic [4:0]  RESULT_LIMIT = 5'd17;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_OPEN = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [12:0] fat_addr;
    logic [7:0]  fat_byte;
    logic [11:0] first_cluster;
    logic [31:0] file_size;
    logic        open_root;
    logic        is_directory;
    logic [13:0] byte_count;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

endpackage

@@ hdl/fat12_file_sector_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// FAT12 file sector sequencer
// Channel   | Ports                          | Handshake
// item in   | op_i .. byte_count_i           | start & !busy
// result    | buffer_offset_o .. last_o      | strobe_o, one cycle
// config    | cfg_idx_i, cfg_wdata_i         | cfg_we_i
// A read yields up to 17 chunks. A chunk that moves to the next cluster
// first reads the FAT entry (two FAT memory reads) and then does the LBA
// multiply; the multiply is skipped when the chain ends there.
// A 2-entry queue decouples intake; busy when full. Results cannot stall.
// Reset clears cursor and config (sectors per cluster resets to 1); FAT store contents are undefined.
// ----------------------------------------------------------------------------
module fat12_file_sector_sequencer_core #(
  parameter int unsigned FAT_STORE_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [12:0] fat_addr_i,
  input  logic [7:0]  fat_byte_i,
  input  logic [11:0] first_cluster_i,
  input  logic [31:0] file_size_i,
  input  logic        open_root_i,
  input  logic        is_directory_i,
  input  logic [13:0] byte_count_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        strobe_o,
  output logic [8:0]  buffer_offset_o,
  output logic [9:0]  take_bytes_o,
  output logic        fetch_o,
  output logic [31:0] fetch_lba_o,
  output logic        end_of_chain_o,
  output logic        last_o
);
  import fat12fss_pkg::*;
  `include "fat12_file_sector_sequencer_core_assert.svh"

  logic   push, pop, full;
  item_t  item;
  q_out_t q;

  fat12fss_front #(.FAT_STORE_BYTES(FAT_STORE_BYTES)) u_front (
    .start_i(start), .full_i(full), .op_i, .fat_addr_i, .fat_byte_i,
    .first_cluster_i, .file_size_i, .open_root_i, .is_directory_i,
    .byte_count_i, .busy_o(busy), .push_o(push), .item_o(item)
  );

  fat12fss_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(item), .pop_i(pop),
    .full_o(full), .q_o(q)
  );

  fat12fss_back #(.FAT_STORE_BYTES(FAT_STORE_BYTES)) u_back (
    .clk_i, .rst_ni, .q_i(q), .pop_o(pop), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .strobe_o, .buffer_offset_o, .take_bytes_o, .fetch_o, .fetch_lba_o,
    .end_of_chain_o, .last_o
  );

  `FSS_ASSERT(a_lba_zero, clk_i, rst_ni, (strobe_o && !fetch_o) |-> (fetch_lba_o == 32'd0))
  `FSS_ASSERT(a_eoc_last, clk_i, rst_ni, (strobe_o && end_of_chain_o) |-> (last_o && !fetch_o))
  `FSS_ASSERT(a_in_sector, clk_i, rst_ni, strobe_o |-> ((11'(buffer_offset_o) + 11'(take_bytes_o)) <= 11'd512))
  `FSS_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop && !q.valid)

endmodule

@@ hdl/fat12fss_front.sv @@
// ----------------------------------------------------------------------------
// FAT12 sector sequencer front end
// Accepts items, drops unused ones and loads beyond the FAT store, saturates read length, pushes to queue.
// ----------------------------------------------------------------------------
module fat12fss_front #(
  parameter int unsigned FAT_STORE_BYTES = 8192
) (
  input  logic                  start_i,
  input  logic                  full_i,
  input  logic [1:0]            op_i,
  input  logic [12:0]           fat_addr_i,
  input  logic [7:0]            fat_byte_i,
  input  logic [11:0]           first_cluster_i,
  input  logic [31:0]           file_size_i,
  input  logic                  open_root_i,
  input  logic                  is_directory_i,
  input  logic [13:0]           byte_count_i,
  output logic                  busy_o,
  output logic                  push_o,
  output fat12fss_pkg::item_t   item_o
);
  import fat12fss_pkg::*;

  logic keep;

  always_comb begin
    item_o.kind          = KIND_LOAD;
    item_o.fat_addr      = fat_addr_i;
    item_o.fat_byte      = fat_byte_i;
    item_o.first_cluster = first_cluster_i;
    item_o.file_size     = file_size_i;
    item_o.open_root     = open_root_i;
    item_o.is_directory  = is_directory_i;
    item_o.byte_count    = (byte_count_i > 14'(MaxReadBytes)) ? 14'(MaxReadBytes)
                                                              : byte_count_i;
    keep = 1'b0;
    case (op_i)
      OP_LOAD: begin
        item_o.kind = KIND_LOAD;
        keep = (32'(fat_addr_i) < 32'(FAT_STORE_BYTES));
      end
      OP_OPEN: begin
        item_o.kind = KIND_OPEN;
        keep = 1'b1;
      end
      OP_READ: begin
        item_o.kind = KIND_READ;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy_o = full_i;
  assign push_o = start_i & ~full_i & keep;

endmodule

@@ hdl/fat12fss_fifo.sv @@
// ----------------------------------------------------------------------------
// FAT12 sector sequencer item queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module fat12fss_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fat12fss_pkg::item_t    item_i,
  input  logic                   pop_i,
  output logic                   full_o,
  output fat12fss_pkg::q_out_t   q_o
);
  import fat12fss_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assign full_o     = (cnt_q == 2'd2);
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.item   = mem_q[rptr_q];

endmodule

@@ hdl/fat12fss_back.sv @@
// ----------------------------------------------------------------------------
// FAT12 sector sequencer back end
// FAT store, read cursor and sector chunk sequencer.
// ----------------------------------------------------------------------------
module fat12fss_back #(
  parameter int unsigned FAT_STORE_BYTES = 8192
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fat12fss_pkg::q_out_t  q_i,
  output logic                  pop_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [31:0]           cfg_wdata_i,
  output logic                  strobe_o,
  output logic [8:0]            buffer_offset_o,
  output logic [9:0]            take_bytes_o,
  output logic                  fetch_o,
  output logic [31:0]           fetch_lba_o,
  output logic                  end_of_chain_o,
  output logic                  last_o
);
  import fat12fss_pkg::*;

  localparam int unsigned AW = $clog2(FAT_STORE_BYTES);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_CHUNK = 6'b000100,
    ST_FAT0  = 6'b001000,
    ST_FAT1  = 6'b010000,
    ST_FAT2  = 6'b100000
  } state_e;

  logic [7:0]  mem_q [FAT_STORE_BYTES];
  logic [7:0]  rdata_q, b0_q, b0_d;
  logic [AW-1:0] raddr;

  state_e      state_q, state_d;
  logic        base_pend_q, base_pend_d;
  logic [7:0]  spc_q;
  logic [31:0] data_lba_q, root_lba_q;
  logic [20:0] root_size_q;

  logic [31:0] pos_q, pos_d, size_q, size_d, cos_q, cos_d, base_q, base_d;
  logic [7:0]  sic_q, sic_d;
  logic        root_q, root_d, dir_q, dir_d;
  logic [13:0] cnt_q, cnt_d;
  logic [4:0]  k_q, k_d;
  logic [8:0]  offs_q, offs_d;
  logic [9:0]  takes_q, takes_d;

  logic        stb_d, fetch_d, eoc_d, last_d;
  logic [8:0]  off_d;
  logic [9:0]  take_d;
  logic [31:0] lba_d;

  logic [8:0]  off;
  logic [9:0]  room, take;
  logic [31:0] left, pos_n;
  logic [13:0] cnt_n;
  logic [7:0]  sic_n;
  logic [4:0]  k_n;
  logic        lim;
  logic [12:0] idx;
  logic [15:0] word;
  logic [11:0] nxt;
  logic [31:0] mul_a, prod;
  logic [31:0] open_lba;

  assign idx   = {1'b0, cos_q[11:0]} + {2'b0, cos_q[11:1]};
  assign raddr = (state_q == ST_FAT1) ? AW'(idx + 13'd1) : AW'(idx);
  assign word  = {rdata_q, b0_q};
  assign nxt   = cos_q[0] ? word[15:4] : (word[11:0] & CLUSTER_MASK);

  assign mul_a    = (state_q == ST_IDLE) ? 32'(q_i.item.first_cluster) - 32'd2
                                         : cos_q - 32'd2;
  assign prod     = mul_a * 32'(spc_q);
  assign open_lba = data_lba_q + prod;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_i.valid && q_i.item.kind == KIND_LOAD) begin
      mem_q[AW'(q_i.item.fat_addr)] <= q_i.item.fat_byte;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    state_d = state_q;
    base_pend_d = 1'b0;
    pos_d = pos_q; size_d = size_q; cos_d = cos_q; base_d = base_q;
    sic_d = sic_q; root_d = root_q; dir_d = dir_q;
    cnt_d = cnt_q; k_d = k_q; offs_d = offs_q; takes_d = takes_q; b0_d = b0_q;
    stb_d = 1'b0; off_d = 9'd0; take_d = 10'd0; fetch_d = 1'b0;
    lba_d = 32'd0; eoc_d = 1'b0; last_d = 1'b0;
    pop_o = 1'b0;

    off   = pos_q[8:0];
    room  = 10'(SectorBytes) - 10'(off);
    take  = (cnt_q < 14'(room)) ? cnt_q[9:0] : room;
    pos_n = pos_q + 32'(take);
    cnt_n = cnt_q - 14'(take);
    sic_n = sic_q + 8'd1;
    k_n   = k_q + 5'd1;
    lim   = (cnt_n == 14'd0) || (k_n == RESULT_LIMIT);
    left  = (pos_q < size_q) ? size_q - pos_q : 32'd0;

    if (base_pend_q) begin
      base_d  = open_lba;
      stb_d   = 1'b1;
      off_d   = offs_q;
      take_d  = takes_q;
      fetch_d = 1'b1;
      lba_d   = open_lba;
      last_d  = (cnt_q == 14'd0) || (k_q == RESULT_LIMIT);
      state_d = last_d ? ST_IDLE : ST_CHUNK;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_i.valid) begin
            pop_o = 1'b1;
            case (q_i.item.kind)
              KIND_OPEN: begin
                pos_d = 32'd0;
                sic_d = 8'd0;
                stb_d = 1'b1; fetch_d = 1'b1; last_d = 1'b1;
                if (q_i.item.open_root) begin
                  root_d = 1'b1; dir_d = 1'b1;
                  size_d = 32'(root_size_q);
                  cos_d  = root_lba_q;
                  lba_d  = root_lba_q;
                end else begin
                  root_d = 1'b0; dir_d = q_i.item.is_directory;
                  size_d = q_i.item.file_size;
                  cos_d  = 32'(q_i.item.first_cluster);
                  lba_d  = open_lba;
                  base_d = open_lba;
                end
              end
              KIND_READ: begin
                cnt_d   = q_i.item.byte_count;
                state_d = ST_PREP;
              end
              default: ;
            endcase
          end
        end
        ST_PREP: begin
          k_d = 5'd0;
          base_d = open_lba;
          if ((!dir_q || size_q != 32'd0) && 32'(cnt_q) > left) begin
            cnt_d = left[13:0];
          end
          if ((!dir_q || size_q != 32'd0) && left == 32'd0 || cnt_q == 14'd0) begin
            stb_d = 1'b1; off_d = off; last_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_CHUNK;
          end
        end
        ST_CHUNK: begin
          pos_d = pos_n; cnt_d = cnt_n; k_d = k_n;
          offs_d = off; takes_d = take;
          off_d = off; take_d = take; last_d = lim;
          state_d = lim ? ST_IDLE : ST_CHUNK;
          if (take != room) begin
            stb_d = 1'b1;
          end else if (root_q) begin
            cos_d = cos_q + 32'd1;
            stb_d = 1'b1; fetch_d = 1'b1; lba_d = cos_q + 32'd1;
          end else if (sic_n >= spc_q) begin
            sic_d   = 8'd0;
            state_d = ST_FAT0;
          end else begin
            sic_d = sic_n;
            stb_d = 1'b1;
            if (cos_q >= 32'(CHAIN_END)) begin
              size_d = pos_n; eoc_d = 1'b1; last_d = 1'b1;
              state_d = ST_IDLE;
            end else begin
              fetch_d = 1'b1; lba_d = base_q + 32'(sic_n);
            end
          end
        end
        ST_FAT0: state_d = ST_FAT1;
        ST_FAT1: begin
          b0_d    = rdata_q;
          state_d = ST_FAT2;
        end
        ST_FAT2: begin
          cos_d = 32'(nxt);
          if (nxt >= CHAIN_END) begin
            size_d = pos_q;
            stb_d = 1'b1; off_d = offs_q; take_d = takes_q;
            eoc_d = 1'b1; last_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            base_pend_d = 1'b1;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; base_pend_q <= 1'b0;
      spc_q <= 8'd1; data_lba_q <= 32'd0; root_lba_q <= 32'd0; root_size_q <= 21'd0;
      pos_q <= 32'd0; size_q <= 32'd0; cos_q <= 32'd0; sic_q <= 8'd0;
      root_q <= 1'b0; dir_q <= 1'b0; cnt_q <= 14'd0; k_q <= 5'd0;
      strobe_o <= 1'b0;
    end else begin
      state_q <= state_d; base_pend_q <= base_pend_d;
      pos_q <= pos_d; size_q <= size_d; cos_q <= cos_d; sic_q <= sic_d;
      root_q <= root_d; dir_q <= dir_d; cnt_q <= cnt_d; k_q <= k_d;
      strobe_o <= stb_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SPC:       spc_q       <= cfg_wdata_i[7:0];
          CFG_DATA_LBA:  data_lba_q  <= cfg_wdata_i;
          CFG_ROOT_LBA:  root_lba_q  <= cfg_wdata_i;
          CFG_ROOT_SIZE: root_size_q <= cfg_wdata_i[20:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d; offs_q <= offs_d; takes_q <= takes_d; b0_q <= b0_d;
    buffer_offset_o <= off_d; take_bytes_o <= take_d; fetch_o <= fetch_d;
    fetch_lba_o <= lba_d; end_of_chain_o <= eoc_d; last_o <= last_d;
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// FAT12 file sector sequencer testbench
// Loads a small FAT, opens files, chains and the root directory, and splits
// reads into sector chunks. Each chunk is checked field by field against a
// built-in cursor model, under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import fat12fss_pkg::*;

  localparam logic [1:0] OpUnused  = 2'd3;
  localparam int         TblClus   = 32;
  localparam int         TblBytes  = TblClus * 3 / 2;
  localparam int         CycLimit  = 400000;
  localparam int         SettleCyc = 60;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] size;
    logic [31:0] cs;
    logic [7:0]  sic;
    logic        is_root;
    logic        is_dir;
  } cursor_t;

  typedef struct packed {
    logic [8:0]  off;
    logic [9:0]  take;
    logic        fetch;
    logic [31:0] lba;
    logic        eoc;
    logic        last;
  } chunk_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] fa;
    logic [7:0]  fb;
    logic [11:0] fc;
    logic [31:0] fs;
    logic        orot;
    logic        isdir;
    logic [13:0] bc;
  } req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [12:0] fat_addr_i;
  logic [7:0]  fat_byte_i;
  logic [11:0] first_cluster_i;
  logic [31:0] file_size_i;
  logic        open_root_i;
  logic        is_directory_i;
  logic [13:0] byte_count_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        strobe_o;
  logic [8:0]  buffer_offset_o;
  logic [9:0]  take_bytes_o;
  logic        fetch_o;
  logic [31:0] fetch_lba_o;
  logic        end_of_chain_o;
  logic        last_o;

  fat12_file_sector_sequencer_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(op_i), .fat_addr_i(fat_addr_i), .fat_byte_i(fat_byte_i),
    .first_cluster_i(first_cluster_i), .file_size_i(file_size_i),
    .open_root_i(open_root_i), .is_directory_i(is_directory_i),
    .byte_count_i(byte_count_i), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .strobe_o(strobe_o),
    .buffer_offset_o(buffer_offset_o), .take_bytes_o(take_bytes_o),
    .fetch_o(fetch_o), .fetch_lba_o(fetch_lba_o),
    .end_of_chain_o(end_of_chain_o), .last_o(last_o)
  );

  logic [7:0]  fat_img   [0:8191];
  bit          fat_known [0:8191];
  cursor_t     cur;
  logic [7:0]  spc;
  logic [31:0] dlba;
  logic [31:0] rlba;
  logic [20:0] rbytes;
  chunk_t      chunk_q[$];
  req_t        req_q[$];
  int          errors;
  int          cycles;
  int          gap_cnt;
  bit          took;
  bit          burst;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [31:0] clus_lba(input logic [31:0] c);
    return dlba + (c - 32'd2) * {24'd0, spc};
  endfunction

  function automatic logic [31:0] next_cluster(input logic [31:0] c, inout bit bad);
    logic [31:0] idx;
    logic [15:0] w;
    idx = {16'd0, c[15:0]} * 3 / 2;
    w = '0;
    if (idx < 8192) begin
      w[7:0] = fat_img[idx];
      if (!fat_known[idx]) bad = 1'b1;
    end
    if (idx + 1 < 8192) begin
      w[15:8] = fat_img[idx + 1];
      if (!fat_known[idx + 1]) bad = 1'b1;
    end
    return c[0] ? {20'd0, w[15:4]} : {20'd0, w[11:0]};
  endfunction

  // returns 1 if the walk would touch FAT bytes never loaded
  function automatic bit plan_read(inout cursor_t c, input logic [13:0] bc,
                                   inout chunk_t q[$]);
    logic [31:0] cnt, left, off, room, take;
    chunk_t ch;
    bit bad;
    int k;
    bad = 1'b0;
    k = 0;
    cnt = (bc > MaxReadBytes) ? MaxReadBytes : {18'd0, bc};
    if (!c.is_dir || c.size != 0) begin
      left = (c.pos < c.size) ? c.size - c.pos : 32'd0;
      if (cnt > left) cnt = left;
    end
    if (cnt == 0) begin
      ch = '0;
      ch.off = c.pos[8:0];
      ch.last = 1'b1;
      q.push_back(ch);
      return bad;
    end
    while (cnt > 0 && k < RESULT_LIMIT) begin
      off = c.pos % SectorBytes;
      room = SectorBytes - off;
      take = (cnt < room) ? cnt : room;
      ch = '0;
      ch.off = off[8:0];
      ch.take = take[9:0];
      c.pos += take;
      cnt -= take;
      if (take == room) begin
        if (c.is_root) begin
          c.cs += 1;
          ch.fetch = 1'b1;
          ch.lba = c.cs;
        end else begin
          c.sic += 8'd1;
          if (c.sic >= spc) begin
            c.sic = '0;
            c.cs = next_cluster(c.cs, bad);
          end
          if (c.cs >= {20'd0, CHAIN_END}) begin
            c.size = c.pos;
            ch.eoc = 1'b1;
          end else begin
            ch.fetch = 1'b1;
            ch.lba = clus_lba(c.cs) + {24'd0, c.sic};
          end
        end
      end
      k++;
      if (cnt == 0 || k == RESULT_LIMIT || ch.eoc) ch.last = 1'b1;
      q.push_back(ch);
      if (ch.eoc) break;
    end
    return bad;
  endfunction

  task automatic add_item(input req_t r);
    cursor_t t;
    chunk_t tmp[$];
    chunk_t ch;
    case (r.op)
      OP_LOAD: begin
        fat_img[r.fa] = r.fb;
        fat_known[r.fa] = 1'b1;
      end
      OP_OPEN: begin
        cur.pos = '0;
        cur.sic = '0;
        ch = '0;
        ch.fetch = 1'b1;
        ch.last = 1'b1;
        if (r.orot) begin
          cur.is_root = 1'b1;
          cur.is_dir = 1'b1;
          cur.size = {11'd0, rbytes};
          cur.cs = rlba;
          ch.lba = rlba;
        end else begin
          cur.is_root = 1'b0;
          cur.is_dir = r.isdir;
          cur.size = r.fs;
          cur.cs = {20'd0, r.fc};
          ch.lba = clus_lba(cur.cs);
        end
        chunk_q.push_back(ch);
      end
      OP_READ: begin
        t = cur;
        if (plan_read(t, r.bc, tmp)) r.bc = '0;
        void'(plan_read(cur, r.bc, chunk_q));
      end
      default: ;
    endcase
    req_q.push_back(r);
  endtask

  function automatic req_t make_req(input logic [1:0] op, input logic [12:0] fa,
                                    input logic [7:0] fb, input logic [11:0] fc,
                                    input logic [31:0] fs, input logic orot,
                                    input logic isdir, input logic [13:0] bc);
    req_t r;
    r.op = op; r.fa = fa; r.fb = fb; r.fc = fc;
    r.fs = fs; r.orot = orot; r.isdir = isdir; r.bc = bc;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int sel;
    r.fa = 13'($urandom); r.fb = 8'($urandom); r.fc = 12'($urandom); r.fs = $urandom;
    r.orot = 1'($urandom); r.isdir = 1'($urandom); r.bc = 14'($urandom_range(0, 8192));
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      r.op = OP_LOAD;
      if ($urandom_range(0, 3) != 0) r.fa = 13'($urandom_range(0, TblBytes - 1));
    end else if (sel < 30) begin
      r.op = OP_OPEN;
      if ($urandom_range(0, 4) != 0) r.fc = 12'($urandom_range(0, TblClus - 1));
      if ($urandom_range(0, 3) != 0) r.fs = $urandom_range(0, 12000);
      r.orot = ($urandom_range(0, 3) == 0);
    end else if (sel < 96) begin
      r.op = OP_READ;
      case ($urandom_range(0, 3))
        0: r.bc = 14'($urandom_range(0, 600));
        1: r.bc = 14'd8192;
        default: ;
      endcase
    end else begin
      r.op = OpUnused;
    end
    return r;
  endfunction

  task automatic drain();
    wait (req_q.size() == 0 && !start);
    wait (chunk_q.size() == 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_cfg(input logic [7:0] s, input logic [31:0] d,
                         input logic [31:0] rl, input logic [20:0] rb);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_SPC; cfg_wdata_i <= {24'd0, s};
    @(negedge clk_i);
    cfg_idx_i <= CFG_DATA_LBA; cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_idx_i <= CFG_ROOT_LBA; cfg_wdata_i <= rl;
    @(negedge clk_i);
    cfg_idx_i <= CFG_ROOT_SIZE; cfg_wdata_i <= {11'd0, rb};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    spc = s; dlba = d; rlba = rl; rbytes = rb;
  endtask

  // item driver
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took)) begin
      if (gap_cnt > 0) begin
        start <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (req_q.size() > 0) begin
        req_t r;
        r = req_q.pop_front();
        op_i <= r.op; fat_addr_i <= r.fa; fat_byte_i <= r.fb;
        first_cluster_i <= r.fc; file_size_i <= r.fs; open_root_i <= r.orot;
        is_directory_i <= r.isdir; byte_count_i <= r.bc;
        start <= 1'b1;
        gap_cnt <= (burst || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    took <= start && !busy;
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (strobe_o) begin
      chunk_t got;
      chunk_t want;
      got = '{buffer_offset_o, take_bytes_o, fetch_o, fetch_lba_o, end_of_chain_o,
              last_o};
      if (chunk_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected chunk: %p", got);
      end else begin
        want = chunk_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("chunk mismatch: exp off=%0d take=%0d fetch=%0d lba=%h eoc=%0d last=%0d, act off=%0d take=%0d fetch=%0d lba=%h eoc=%0d last=%0d",
                     want.off, want.take, want.fetch, want.lba, want.eoc, want.last,
                     got.off, got.take, got.fetch, got.lba, got.eoc, got.last);
        end
      end
    end
  end

  initial begin
    logic [11:0] nxt [0:TblClus-1];
    logic [7:0]  tbl [0:TblBytes-1];
    int idx;
    rst_ni = 1'b0; start = 1'b0; op_i = '0; fat_addr_i = '0; fat_byte_i = '0;
    first_cluster_i = '0; file_size_i = '0; open_root_i = 1'b0;
    is_directory_i = 1'b0; byte_count_i = '0; cfg_we_i = 1'b0; cfg_idx_i = '0;
    cfg_wdata_i = '0; errors = 0; cycles = 0; gap_cnt = 0; took = 1'b0; burst = 1'b0;
    cur = '0; spc = 8'd1; dlba = '0; rlba = '0; rbytes = '0;
    for (int i = 0; i < 8192; i++) begin
      fat_img[i] = '0;
      fat_known[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // chain table: clusters 4..31 run straight and end at 31, 2 links to 3 which ends, 0 and 1 random or ending
    for (int c = 0; c < TblClus; c++)
      nxt[c] = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(12'hFF8, 12'hFFF))
                                           : 12'($urandom_range(2, TblClus - 1));
    for (int c = 4; c < 31; c++) nxt[c] = 12'(c + 1);
    nxt[31] = 12'hFF8;
    nxt[2] = 12'd3;
    nxt[3] = 12'hFFF;
    for (int c = 0; c < TblClus; c++) begin
      idx = c * 3 / 2;
      if (c % 2 == 0) begin
        tbl[idx] = nxt[c][7:0];
        tbl[idx + 1][3:0] = nxt[c][11:8];
      end else begin
        tbl[idx][7:4] = nxt[c][3:0];
        tbl[idx + 1] = nxt[c][11:4];
      end
    end
    burst = 1'b1;
    for (int i = 0; i < TblBytes; i++)
      add_item(make_req(OP_LOAD, 13'(i), tbl[i], '0, '0, 1'b0, 1'b0, '0));
    burst = 1'b0;

    // directed items
    add_item(make_req(OP_LOAD, 13'h1FFF, 8'hFF, '0, '0, 1'b0, 1'b0, '0));
    add_item(make_req(OP_LOAD, 13'h1000, 8'h00, '0, '0, 1'b0, 1'b0, '0));
    add_item(make_req(OpUnused, 13'h1FFF, 8'hFF, 12'hFFF, '1, 1'b1, 1'b1, 14'd8192));
    add_item(make_req(OP_OPEN, '0, '0, '0, '0, 1'b1, 1'b0, '0));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd8192));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd0));
    add_item(make_req(OP_OPEN, '0, '0, 12'd2, 32'd2000, 1'b0, 1'b0, '0));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd8192));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd10));
    add_item(make_req(OP_OPEN, '0, '0, 12'd0, 32'd0, 1'b0, 1'b0, '0));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd5));
    add_item(make_req(OP_OPEN, '0, '0, 12'd1, 32'd0, 1'b0, 1'b1, '0));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd300));
    add_item(make_req(OP_OPEN, '0, '0, 12'hFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, '0));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd100));
    add_item(make_req(OP_OPEN, '0, '0, 12'd4, 32'd100000, 1'b0, 1'b0, '0));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd100));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd8192));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd8191));
    for (int i = 0; i < 5; i++) add_item(rand_req());

    set_cfg(8'd128, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 21'd2097120);
    add_item(make_req(OP_OPEN, '0, '0, '0, '0, 1'b1, 1'b0, '0));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd8192));
    add_item(make_req(OP_OPEN, '0, '0, 12'd0, 32'd5000, 1'b0, 1'b0, '0));
    add_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0, 1'b0, 14'd8192));
    burst = 1'b1;
    for (int i = 0; i < 8; i++) add_item(rand_req());
    drain();
    burst = 1'b0;

    set_cfg(8'($urandom_range(2, 8)), $urandom, $urandom,
            21'($urandom_range(0, 512) * 32));
    for (int i = 0; i < 8; i++) add_item(rand_req());

    set_cfg(8'd1, 32'd100, 32'd40, 21'd4096);
    for (int i = 0; i < 8; i++) add_item(rand_req());

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
